@@ rtl/sme_pkg.sv @@
// ---------------------------------------------------------------------------
// Stack machine execute package
// Shared widths, action codes, status codes, state and command types.
// ---------------------------------------------------------------------------
`default_nettype none
package sme_pkg;
  localparam int DATA_DEPTH   = 64;
  localparam int RETURN_DEPTH = 16;
  localparam int NUM_REGS     = 4;
  localparam int PC_BITS      = 16;
  localparam int DC_BITS      = $clog2(DATA_DEPTH + 1);
  localparam int DA_BITS      = $clog2(DATA_DEPTH);
  localparam int RC_BITS      = $clog2(RETURN_DEPTH + 1);
  localparam int RA_BITS      = $clog2(RETURN_DEPTH);
  localparam int RI_BITS      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [4:0] {
    A_HLT = 5'd0, A_PUSH = 5'd1, A_POP = 5'd2, A_ADD = 5'd3, A_SUB = 5'd4,
    A_MUL = 5'd5, A_SQRT = 5'd6, A_DIV = 5'd7, A_OUT = 5'd8, A_VER = 5'd9,
    A_DMP = 5'd10, A_IN = 5'd11, A_JMP = 5'd12, A_JA = 5'd13, A_JAE = 5'd14,
    A_JB = 5'd15, A_JBE = 5'd16, A_JE = 5'd17, A_JNE = 5'd18, A_CALL = 5'd19,
    A_RET = 5'd20
  } action_t;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0, ST_HALT = 3'd1, ST_UNDER = 3'd2, ST_OVER = 3'd3,
    ST_BADCMD = 3'd4, ST_NEGSQRT = 3'd5, ST_PASTEND = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_ITER, S_DONE, S_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;     // capture the instruction
    logic rd;       // issue stack reads
    logic exec;     // evaluate the instruction
    logic start;    // start the iterative unit
    logic step;     // one iterative step
    logic commit;   // write back results
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_iter; // instruction uses the iterative unit
    logic iter_last; // last iterative step
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/sme_if.sv @@
// ---------------------------------------------------------------------------
// Stack machine execute channels
// Valid/ready channels for instructions, results and configuration.
// ---------------------------------------------------------------------------
`default_nettype none
interface sme_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  action;
  logic        imm_flag;
  logic        reg_flag;
  logic signed [31:0] immediate;
  logic [1:0]  reg_index;
  logic signed [63:0] entered_value;
  modport source (output valid, action, imm_flag, reg_flag, immediate, reg_index,
                  entered_value, input ready);
  modport sink (input valid, action, imm_flag, reg_flag, immediate, reg_index,
                entered_value, output ready);
endinterface

interface sme_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [2:0]  status;
  logic        out_valid;
  logic signed [63:0] out_value;
  modport source (output valid, next_pc, status, out_valid, out_value, input ready);
  modport sink (input valid, next_pc, status, out_valid, out_value, output ready);
endinterface

interface sme_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/stack_machine_execute.sv @@
// ---------------------------------------------------------------------------
// Stack machine execute stage
// Executes one decoded instruction at a time and reports pc and status.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload
// inst      in   action, imm_flag, reg_flag, immediate, reg_index, entered_value
// res       out  next_pc, status, out_valid, out_value
// cfg       in   program_length
// A simple instruction passes the read, execute and done states before result valid rises.
// Multiply adds 4 steps of a 64x16 multiplier, divide 80 and sqrt 40
// steps of the shared shift-subtract unit.
// Reset (rst, synchronous) clears pc, counts, registers and halt flag.
// A stalled result holds; the next instruction is taken once it is consumed.
`default_nettype none
module stack_machine_execute
  import sme_pkg::*;
(
  input wire clk,
  input wire rst,
  sme_in_if.sink   inst,
  sme_out_if.source res,
  sme_cfg_if.sink  cfg
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  sme_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(inst.valid), .in_ready(inst.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .stat, .cmd
  );

  sme_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .action(inst.action), .imm_flag(inst.imm_flag), .reg_flag(inst.reg_flag),
    .immediate(inst.immediate), .reg_index(inst.reg_index),
    .entered_value(inst.entered_value),
    .cfg_we(cfg.valid), .cfg_data(cfg.data),
    .next_pc(res.next_pc), .status(res.status),
    .out_valid(res.out_valid), .out_value(res.out_value)
  );

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    !(inst.ready && res.valid)) else $error("accept and result overlap");
  a_res_after: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready) |=> inst.ready) else $error("no return to idle");
  a_nv_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.out_valid) |-> res.out_value == 64'd0)
    else $error("out_value without out_valid");
endmodule
`default_nettype wire

@@ rtl/sme_ctrl.sv @@
// ---------------------------------------------------------------------------
// Stack machine execute controller
// Sequences capture, stack read, evaluation, iteration and result handoff.
// ---------------------------------------------------------------------------
`default_nettype none
module sme_ctrl
  import sme_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic res_valid,
  input  wire  res_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.need_iter) begin
          cmd.start = 1'b1;
          state_next = S_ITER;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_DONE;
        end
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (stat.iter_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/sme_dp.sv @@
// ---------------------------------------------------------------------------
// Stack machine execute datapath
// Stacks, registers, pc, saturating arithmetic and a shared iterative unit
// for multiply (one 64x16 partial product per step), divide and sqrt.
// ---------------------------------------------------------------------------
`default_nettype none
module sme_dp
  import sme_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  cmd_t cmd,
  output stat_t stat,
  input  wire [4:0]  action,
  input  wire        imm_flag,
  input  wire        reg_flag,
  input  wire [31:0] immediate,
  input  wire [1:0]  reg_index,
  input  wire [63:0] entered_value,
  input  wire        cfg_we,
  input  wire [15:0] cfg_data,
  output logic [15:0] next_pc,
  output logic [2:0]  status,
  output logic        out_valid,
  output logic [63:0] out_value
);
  localparam logic [63:0] SIGN = {1'b1, 63'd0};
  localparam logic [63:0] MAXV = {1'b0, {63{1'b1}}};

  logic [63:0] dmem [DATA_DEPTH];
  logic [PC_BITS-1:0] rmem [RETURN_DEPTH];
  logic [31:0] regs [NUM_REGS];
  logic [PC_BITS-1:0] pc;
  logic halted;
  logic [DC_BITS-1:0] dcnt;
  logic [RC_BITS-1:0] rcnt;
  logic [15:0] plen;

  logic [4:0] act;
  logic immf, regf;
  logic [31:0] imm;
  logic [1:0] ridx;
  logic [63:0] ent;
  logic [63:0] a, b;
  logic [PC_BITS-1:0] rtop;

  // Result of evaluation, held until commit.
  logic [2:0] st;
  logic [PC_BITS-1:0] npc;
  logic d_we, r_push, reg_we;
  logic [DA_BITS-1:0] d_addr;
  logic [63:0] d_val;
  logic [DC_BITS-1:0] dcnt_n;
  logic [RC_BITS-1:0] rcnt_n;
  logic [31:0] reg_val;
  logic ov;
  logic [63:0] oval;
  logic set_halt;

  // Iterative unit.
  logic [1:0] op;   // 0 mul, 1 div, 2 sqrt
  logic [6:0] cnt;
  logic [79:0] acc;   // mul multiplier bits / div dividend bits / sqrt radicand
  logic [81:0] rem;
  logic [63:0] q;
  logic [63:0] divisor, mula;
  logic big, negr;
  logic [127:0] prod;

  always_ff @(posedge clk) begin
    if (rst) plen <= '0;
    else if (cfg_we) plen <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action; immf <= imm_flag; regf <= reg_flag;
      imm <= immediate; ridx <= reg_index; ent <= entered_value;
    end
    if (cmd.rd) begin
      a <= dmem[DA_BITS'(dcnt - DC_BITS'(1))];
      b <= dmem[DA_BITS'(dcnt - DC_BITS'(2))];
      rtop <= rmem[RA_BITS'(rcnt - RC_BITS'(1))];
    end
  end

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] satmag(input logic [63:0] m, input logic n,
                                         input logic bg);
    if (n) satmag = (bg || m > SIGN) ? SIGN : (64'd0 - m);
    else satmag = (bg || m > MAXV) ? MAXV : m;
  endfunction

  wire live = !halted && ({{(32-PC_BITS){1'b0}}, pc} <= 32'(plen));
  wire is_iter_op = (act == A_MUL || act == A_DIV || act == A_SQRT);
  assign stat.need_iter = live && is_iter_op && dcnt >= DC_BITS'(act == A_SQRT ? 1 : 2)
                          && !(act == A_SQRT && a[63]) && !(act == A_DIV && a == 64'd0);
  assign stat.iter_last = (cnt == 7'd0);

  wire [PC_BITS-1:0] target = imm[PC_BITS-1:0];
  wire [RI_BITS-1:0] ri = ridx[RI_BITS-1:0];
  wire rvalid = 32'(ridx) < 32'(NUM_REGS);

  // Iterative steps.
  wire [81:0] rsh = {rem[79:0], acc[79:78]};
  wire [81:0] trial = {16'd0, q, 2'b01};
  wire [64:0] drem = {rem[63:0], acc[79]};
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= '0; q <= '0; big <= 1'b0; prod <= '0;
      if (act == A_MUL) begin
        op <= 2'd0; cnt <= 7'd3;
        mula <= mag(a); acc <= {16'd0, mag(b)};
        negr <= a[63] ^ b[63];
      end else if (act == A_DIV) begin
        op <= 2'd1; cnt <= 7'd79;
        divisor <= mag(a); acc <= {mag(b), 16'd0};
        negr <= a[63] ^ b[63];
      end else begin
        op <= 2'd2; cnt <= 7'd39;
        acc <= {a, 16'd0}; negr <= 1'b0;
      end
    end else if (cmd.step) begin
      cnt <= cnt - 7'd1;
      unique case (op)
        2'd0: begin
          // Partial product for 16 multiplier bits per step, shifted into place.
          prod <= (prod >> 16) + {{16'd0, mula} * {64'd0, acc[15:0]}, 48'd0};
          acc <= acc >> 16;
        end
        2'd1: begin
          if (q[63]) big <= 1'b1;
          acc <= acc << 1;
          if (drem >= {1'b0, divisor}) begin
            rem <= {17'd0, drem - {1'b0, divisor}};
            q <= {q[62:0], 1'b1};
          end else begin
            rem <= {17'd0, drem};
            q <= {q[62:0], 1'b0};
          end
        end
        default: begin
          acc <= acc << 2;
          if (rsh >= trial) begin
            rem <= rsh - trial; q <= {q[62:0], 1'b1};
          end else begin
            rem <= rsh; q <= {q[62:0], 1'b0};
          end
        end
      endcase
    end
  end

  wire [63:0] mulr = prod[79:16];
  wire mulbig = prod[127:80] != 48'd0;

  function automatic logic [63:0] sadd(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    s = x + y;
    sadd = (x[63] == y[63] && s[63] != x[63]) ? (x[63] ? SIGN : MAXV) : s;
  endfunction
  function automatic logic [63:0] ssub(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] d;
    d = x - y;
    ssub = (x[63] != y[63] && d[63] != x[63]) ? (x[63] ? SIGN : MAXV) : d;
  endfunction

  // Evaluation; iterative results are written back at commit.
  always_ff @(posedge clk) begin
    logic [31:0] arg;
    logic [63:0] t;
    logic [63:0] ax, bx;
    logic take;
    arg = '0; t = '0; ax = a ^ SIGN; bx = b ^ SIGN; take = 1'b0;
    if (cmd.exec || cmd.start) begin
      st <= ST_RUN; npc <= pc; d_we <= 1'b0; r_push <= 1'b0; reg_we <= 1'b0;
      dcnt_n <= dcnt; rcnt_n <= rcnt; ov <= 1'b0; oval <= '0;
      d_addr <= DA_BITS'(dcnt - DC_BITS'(2)); d_val <= '0; reg_val <= '0;
      if (halted) st <= ST_HALT;
      else if (!live) st <= ST_PASTEND;
      else begin
        unique case (act)
          A_HLT: st <= ST_HALT;
          A_PUSH: begin
            if (immf) arg = imm;
            if (regf && rvalid) arg = arg + regs[ri];
            if (dcnt >= DC_BITS'(DATA_DEPTH)) st <= ST_OVER;
            else begin
              d_we <= 1'b1; d_addr <= DA_BITS'(dcnt);
              d_val <= {{16{arg[31]}}, arg, 16'd0};
              dcnt_n <= dcnt + DC_BITS'(1);
              npc <= pc + PC_BITS'(1) + (immf ? PC_BITS'(4) : '0) + (regf ? PC_BITS'(1) : '0);
            end
          end
          A_POP: begin
            if (dcnt == '0) st <= ST_UNDER;
            else begin
              t = mag(a) >> 16;
              if (a[63]) t = 64'd0 - t;
              reg_we <= rvalid; reg_val <= t[31:0];
              dcnt_n <= dcnt - DC_BITS'(1); npc <= pc + PC_BITS'(2);
            end
          end
          A_ADD, A_SUB, A_MUL, A_DIV: begin
            if (dcnt < DC_BITS'(2)) st <= ST_UNDER;
            else begin
              d_we <= 1'b1;
              if (act == A_ADD) d_val <= sadd(b, a);
              else if (act == A_SUB) d_val <= ssub(b, a);
              else if (act == A_DIV && a == '0)
                d_val <= (b == '0) ? 64'd0 : (b[63] ? SIGN : MAXV);
              dcnt_n <= dcnt - DC_BITS'(1); npc <= pc + PC_BITS'(1);
            end
          end
          A_SQRT: begin
            if (dcnt == '0) st <= ST_UNDER;
            else if (a[63]) st <= ST_NEGSQRT;
            else begin
              d_we <= 1'b1; d_addr <= DA_BITS'(dcnt - DC_BITS'(1));
              npc <= pc + PC_BITS'(1);
            end
          end
          A_OUT: begin
            if (dcnt == '0) st <= ST_UNDER;
            else begin
              ov <= 1'b1; oval <= a; dcnt_n <= dcnt - DC_BITS'(1);
              npc <= pc + PC_BITS'(1);
            end
          end
          A_VER, A_DMP: npc <= pc + PC_BITS'(1);
          A_IN: begin
            if (dcnt >= DC_BITS'(DATA_DEPTH)) st <= ST_OVER;
            else begin
              d_we <= 1'b1; d_addr <= DA_BITS'(dcnt); d_val <= ent;
              dcnt_n <= dcnt + DC_BITS'(1); npc <= pc + PC_BITS'(1);
            end
          end
          A_JMP: npc <= target;
          A_JA, A_JAE, A_JB, A_JBE, A_JE, A_JNE: begin
            if (dcnt < DC_BITS'(2)) st <= ST_UNDER;
            else begin
              priority case (act)
                A_JA: take = ax > bx;
                A_JAE: take = ax >= bx;
                A_JB: take = ax < bx;
                A_JBE: take = ax <= bx;
                A_JE: take = ax == bx;
                default: take = ax != bx;
              endcase
              dcnt_n <= dcnt - DC_BITS'(2);
              npc <= take ? target : pc + PC_BITS'(5);
            end
          end
          A_CALL: begin
            if (rcnt >= RC_BITS'(RETURN_DEPTH)) st <= ST_OVER;
            else begin
              r_push <= 1'b1; rcnt_n <= rcnt + RC_BITS'(1); npc <= target;
            end
          end
          A_RET: begin
            if (rcnt == '0) st <= ST_UNDER;
            else begin
              rcnt_n <= rcnt - RC_BITS'(1); npc <= rtop;
            end
          end
          default: st <= ST_BADCMD;
        endcase
      end
    end else if (cmd.step && stat.iter_last) begin
      // The final step's register updates are not visible yet; finish at commit.
    end
  end

  wire [63:0] div_q = {q[62:0], (drem >= {1'b0, divisor})};
  wire div_big = big | q[63];
  logic [63:0] iter_res;
  logic iter_done;
  always_ff @(posedge clk) begin
    if (rst) iter_done <= 1'b0;
    else iter_done <= cmd.step && stat.iter_last;
    if (cmd.step && stat.iter_last) begin
      unique case (op)
        2'd0: iter_res <= 64'd0;
        2'd1: iter_res <= satmag(div_q, negr, div_big);
        default: iter_res <= {q[62:0], (rsh >= trial)};
      endcase
    end
  end

  // Multiply result must see the final accumulated product.
  wire [63:0] wr_val = !iter_done ? d_val :
                       (op == 2'd0) ? satmag(mulr, negr, mulbig) : iter_res;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (d_we) dmem[d_addr] <= wr_val;
      if (r_push) rmem[RA_BITS'(rcnt)] <= pc + PC_BITS'(5);
      next_pc <= 16'(npc);
      status <= st; out_valid <= ov; out_value <= oval;
    end
  end

  assign set_halt = (st == ST_HALT && !halted) || st == ST_UNDER || st == ST_OVER ||
                    st == ST_BADCMD || st == ST_NEGSQRT;
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0; halted <= 1'b0; dcnt <= '0; rcnt <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (cmd.commit) begin
      pc <= npc;
      if (set_halt) halted <= 1'b1;
      dcnt <= dcnt_n; rcnt <= rcnt_n;
      if (reg_we) regs[ri] <= reg_val;
    end
  end
endmodule
`default_nettype wire

@@ verif/tb_stack_machine_execute.sv @@
// ---------------------------------------------------------------------------
// Stack machine execute stage testbench
// Drives decoded instructions with random pacing on both channels, predicts
// each result from a local copy of the machine state and checks every field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_stack_machine_execute;
  import sme_pkg::*;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [4:0]  FIRST_BAD_ACTION = 5'(A_RET) + 5'd1;
  localparam logic [15:0] FULL_LENGTH = 16'hffff;

  typedef struct packed {
    logic [4:0]  action;
    logic        imm_flag;
    logic        reg_flag;
    logic [31:0] immediate;
    logic [1:0]  reg_index;
    logic [63:0] entered_value;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  status;
    logic        out_valid;
    logic [63:0] out_value;
  } result_t;

  class machine_scoreboard;
    logic [15:0] pc;
    bit          halted;
    logic [63:0] dstack[DATA_DEPTH];
    int          dcount;
    logic [15:0] rstack[RETURN_DEPTH];
    int          rcount;
    logic [31:0] regs[NUM_REGS];
    logic [15:0] prog_len;
    result_t     pending_q[$];
    int          errors, mismatches, checked, past_end_seen, outs_seen;

    function new();
      pc = 0; halted = 0; dcount = 0; rcount = 0; prog_len = 0;
      foreach (regs[i]) regs[i] = 0;
      errors = 0; mismatches = 0; checked = 0; past_end_seen = 0; outs_seen = 0;
    endfunction

    function logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function logic [63:0] sat_mag(logic [63:0] m, bit neg, bit big);
      if (neg) return (big || m > SIGN64) ? SIGN64 : -m;
      return (big || m > MAX64) ? MAX64 : m;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SIGN64 : MAX64;
      return s;
    endfunction

    function logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) return a[63] ? SIGN64 : MAX64;
      return d;
    endfunction

    function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      return sat_mag(p[79:16], a[63] ^ b[63], p[127:80] != 0);
    endfunction

    // Quotient of (dividend << 16) by divisor, truncated toward zero.
    function logic [63:0] fx_div(logic [63:0] n, logic [63:0] d);
      logic [79:0] q;
      if (d == 0) return (n == 0) ? 64'd0 : (n[63] ? SIGN64 : MAX64);
      q = {mag(n), 16'b0} / {16'b0, mag(d)};
      return sat_mag(q[63:0], n[63] ^ d[63], q[79:64] != 0);
    endfunction

    function logic [63:0] fx_sqrt(logic [63:0] v);
      logic [79:0] x, sq;
      logic [39:0] root, t;
      x = {v, 16'b0};
      root = 0;
      for (int i = 39; i >= 0; i--) begin
        t = root | (40'd1 << i);
        sq = {40'b0, t} * {40'b0, t};
        if (sq <= x) root = t;
      end
      return {24'b0, root};
    endfunction

    function void note_instruction(instr_t it);
      result_t e;
      logic [31:0] arg;
      logic [63:0] a, b, v, t;
      logic [15:0] npc, tgt;
      bit take;
      e = '0;
      npc = pc;
      tgt = it.immediate[15:0];
      if (halted) e.status = ST_HALT;
      else if (pc > prog_len) e.status = ST_PASTEND;
      else begin
        case (it.action)
          A_HLT: begin
            halted = 1; e.status = ST_HALT;
          end
          A_PUSH, A_IN: begin
            arg = 0;
            if (it.imm_flag) arg += it.immediate;
            if (it.reg_flag) arg += regs[it.reg_index];
            if (dcount >= DATA_DEPTH) e.status = ST_OVER;
            else if (it.action == A_IN) begin
              dstack[dcount++] = it.entered_value;
              npc = pc + 16'd1;
            end else begin
              dstack[dcount++] = {{32{arg[31]}}, arg} << 16;
              npc = pc + 16'd1 + (it.imm_flag ? 16'd4 : 16'd0) + 16'(it.reg_flag);
            end
          end
          A_POP: begin
            if (dcount == 0) e.status = ST_UNDER;
            else begin
              v = dstack[--dcount];
              t = mag(v) >> 16;
              if (v[63]) t = -t;
              regs[it.reg_index] = t[31:0];
              npc = pc + 16'd2;
            end
          end
          A_ADD, A_SUB, A_MUL, A_DIV: begin
            if (dcount < 2) e.status = ST_UNDER;
            else begin
              a = dstack[dcount-1];
              b = dstack[dcount-2];
              dcount--;
              case (it.action)
                A_ADD: dstack[dcount-1] = sat_add(b, a);
                A_SUB: dstack[dcount-1] = sat_sub(b, a);
                A_MUL: dstack[dcount-1] = fx_mul(a, b);
                default: dstack[dcount-1] = fx_div(b, a);
              endcase
              npc = pc + 16'd1;
            end
          end
          A_SQRT: begin
            if (dcount == 0) e.status = ST_UNDER;
            else if (dstack[dcount-1][63]) e.status = ST_NEGSQRT;
            else begin
              dstack[dcount-1] = fx_sqrt(dstack[dcount-1]);
              npc = pc + 16'd1;
            end
          end
          A_OUT: begin
            if (dcount == 0) e.status = ST_UNDER;
            else begin
              e.out_value = dstack[--dcount];
              e.out_valid = 1;
              npc = pc + 16'd1;
            end
          end
          A_VER, A_DMP: npc = pc + 16'd1;
          A_JMP: npc = tgt;
          A_JA, A_JAE, A_JB, A_JBE, A_JE, A_JNE: begin
            if (dcount < 2) e.status = ST_UNDER;
            else begin
              a = dstack[dcount-1];
              b = dstack[dcount-2];
              case (it.action)
                A_JA:  take = $signed(a) >  $signed(b);
                A_JAE: take = $signed(a) >= $signed(b);
                A_JB:  take = $signed(a) <  $signed(b);
                A_JBE: take = $signed(a) <= $signed(b);
                A_JE:  take = a == b;
                default: take = a != b;
              endcase
              dcount -= 2;
              npc = take ? tgt : pc + 16'd5;
            end
          end
          A_CALL: begin
            if (rcount >= RETURN_DEPTH) e.status = ST_OVER;
            else begin
              rstack[rcount++] = pc + 16'd5;
              npc = tgt;
            end
          end
          A_RET: begin
            if (rcount == 0) e.status = ST_UNDER;
            else npc = rstack[--rcount];
          end
          default: e.status = ST_BADCMD;
        endcase
        if (e.status >= ST_UNDER && e.status <= ST_NEGSQRT) halted = 1;
      end
      pc = npc;
      e.next_pc = pc;
      pending_q.push_back(e);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("Unexpected result transaction: %p", got);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.status == ST_PASTEND) past_end_seen++;
      if (got.out_valid) outs_seen++;
      if (got !== e) begin
        errors++;
        if (mismatches++ < 10)
          $display("Mismatch at result %0d: pc %h/%h status %0d/%0d out %b/%b %h/%h",
                   checked, e.next_pc, got.next_pc, e.status, got.status,
                   e.out_valid, got.out_valid, e.out_value, got.out_value);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk, rst;
  sme_in_if  inst();
  sme_out_if res();
  sme_cfg_if cfg();

  stack_machine_execute dut (.clk(clk), .rst(rst), .inst(inst), .res(res), .cfg(cfg));

  machine_scoreboard sb;
  bit calm;
  bit hold_req;
  int hold_cnt;
  int sent;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res.ready = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = 300;
        res.ready <= 0;
      end else begin
        res.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result('{res.next_pc, res.status, res.out_valid, res.out_value});
  end

  task automatic send(instr_t it);
    inst.valid         <= 1;
    inst.action        <= it.action;
    inst.imm_flag      <= it.imm_flag;
    inst.reg_flag      <= it.reg_flag;
    inst.immediate     <= it.immediate;
    inst.reg_index     <= it.reg_index;
    inst.entered_value <= it.entered_value;
    @(posedge clk);
    while (!inst.ready) @(posedge clk);
    sb.note_instruction(it);
    sent++;
    if (!calm && $urandom_range(99) < 31) begin
      inst.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    inst.valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_length(logic [15:0] len);
    drain();
    cfg.valid <= 1;
    cfg.data  <= len;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.prog_len = len;
    cfg.valid <= 0;
  endtask

  function automatic instr_t mk(logic [4:0] act, bit immf, bit regf,
                                logic [31:0] imm, logic [1:0] ridx, logic [63:0] ev);
    return '{act, immf, regf, imm, ridx, ev};
  endfunction

  function automatic logic [63:0] rand_q(int mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 2000)) - 1000) << 16;
      2: return 64'($signed(32'($urandom))) << ($urandom_range(0, 20));
      default: return $urandom_range(0, 3) == 0 ? MAX64 : SIGN64;
    endcase
  endfunction

  // Random instruction that cannot stop the machine, given the predicted state.
  function automatic instr_t rand_legal();
    instr_t it;
    int r;
    it = mk(A_VER, $urandom_range(0, 1), $urandom_range(0, 1), $urandom,
            $urandom_range(0, 3), rand_q($urandom_range(0, 3)));
    forever begin
      r = $urandom_range(0, 99);
      if (r < 22 && sb.dcount < DATA_DEPTH) begin
        it.action = A_PUSH;
        if ($urandom_range(0, 1)) it.immediate = $signed($urandom_range(0, 200)) - 100;
        return it;
      end
      if (r < 30 && sb.dcount < DATA_DEPTH) begin it.action = A_IN; return it; end
      if (r < 36 && sb.dcount > 0) begin it.action = A_POP; return it; end
      if (r < 56 && sb.dcount > 1) begin
        case ($urandom_range(0, 3))
          0: it.action = A_ADD;
          1: it.action = A_SUB;
          2: it.action = A_MUL;
          default: it.action = A_DIV;
        endcase
        return it;
      end
      if (r < 61 && sb.dcount > 0 && !sb.dstack[sb.dcount-1][63]) begin
        it.action = A_SQRT; return it;
      end
      if (r < 67 && sb.dcount > 0) begin it.action = A_OUT; return it; end
      if (r < 70) begin it.action = $urandom_range(0, 1) ? A_VER : A_DMP; return it; end
      if (r < 73) begin it.action = A_JMP; return it; end
      if (r < 86 && sb.dcount > 1) begin
        it.action = 5'($urandom_range(A_JA, A_JNE));
        if ($urandom_range(0, 2) == 0) it.immediate = $urandom;
        return it;
      end
      if (r < 93 && sb.rcount < RETURN_DEPTH) begin it.action = A_CALL; return it; end
      if (r >= 93 && sb.rcount > 0) begin it.action = A_RET; return it; end
    end
  endfunction

  initial begin
    instr_t it;
    sb = new();
    sent = 0;
    calm = 0;
    hold_req = 0;
    rst = 1;
    inst.valid = 0; inst.action = A_HLT; inst.imm_flag = 0; inst.reg_flag = 0;
    inst.immediate = 0; inst.reg_index = 0; inst.entered_value = 0;
    cfg.valid = 0; cfg.data = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a program length of zero, then the arithmetic corners and control flow.
    write_length(16'd0);
    send(mk(A_PUSH, 1, 0, 32'd0, 0, 0));
    send(mk(A_VER, 0, 0, 32'd0, 0, 0));
    write_length(FULL_LENGTH);
    send(mk(A_IN, 0, 0, 0, 0, MAX64));
    send(mk(A_IN, 0, 0, 0, 0, MAX64));
    send(mk(A_ADD, 0, 0, 0, 0, 0));
    send(mk(A_IN, 0, 0, 0, 0, SIGN64));
    send(mk(A_MUL, 0, 0, 0, 0, 0));
    send(mk(A_IN, 0, 0, 0, 0, 64'd0));
    send(mk(A_DIV, 0, 0, 0, 0, 0));
    send(mk(A_PUSH, 1, 0, 32'h7fff_ffff, 0, 0));
    send(mk(A_PUSH, 1, 1, 32'h8000_0000, 3, 0));
    send(mk(A_SUB, 0, 0, 0, 0, 0));
    send(mk(A_POP, 0, 0, 0, 1, 0));
    send(mk(A_PUSH, 1, 1, 32'd5, 1, 0));
    send(mk(A_PUSH, 1, 0, 32'd9, 0, 0));
    send(mk(A_SQRT, 0, 0, 0, 0, 0));
    send(mk(A_OUT, 0, 0, 0, 0, 0));
    send(mk(A_JE, 0, 0, 32'd100, 0, 0));
    send(mk(A_DMP, 0, 0, 0, 0, 0));
    send(mk(A_CALL, 0, 0, 32'd40000, 0, 0));
    send(mk(A_RET, 0, 0, 0, 0, 0));
    send(mk(A_JMP, 0, 0, 32'hffff_1234, 0, 0));
    send(mk(A_PUSH, 0, 0, 0, 2, 0));
    send(mk(A_OUT, 0, 0, 0, 0, 0));

    // Random phases, each under its own program length.
    for (int phase = 0; phase < 11; phase++) begin
      case (phase % 4)
        1: write_length(16'($urandom_range(sb.pc, FULL_LENGTH)));
        2: if (sb.pc > 0) write_length(sb.pc - 16'd1);
        default: write_length(FULL_LENGTH);
      endcase
      calm = (phase == 3);
      if (phase == 5) hold_req = 1;
      for (int n = 0; n < 95; n++) begin
        if (phase % 4 == 2 && n == 5) write_length(FULL_LENGTH);
        send(rand_legal());
      end
      if (phase == 7) drain();
    end
    calm = 0;

    // Finally stop the machine one way or another and keep feeding it.
    case ($urandom_range(0, 4))
      0: send(mk(A_HLT, 0, 0, 0, 0, 0));
      1: send(mk(5'($urandom_range(FIRST_BAD_ACTION, 31)), 1, 1, $urandom, 3, 0));
      2: begin
        while (sb.rcount > 0) send(mk(A_RET, 0, 0, 0, 0, 0));
        send(mk(A_RET, 0, 0, 0, 0, 0));
      end
      3: begin
        send(mk(A_PUSH, 1, 0, 32'hffff_ffff, 0, 0));
        send(mk(A_SQRT, 0, 0, 0, 0, 0));
      end
      default: while (!sb.halted) send(mk(A_PUSH, 1, 0, $urandom, 0, 0));
    endcase
    send(mk(5'd31, 1, 1, 32'hffff_ffff, 3, 64'hffff_ffff_ffff_ffff));
    for (int n = 0; n < 10; n++) send(rand_legal());

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d instructions, checked %0d results (%0d outputs, %0d past end).",
             sent, sb.checked, sb.outs_seen, sb.past_end_seen);
    $display("Machine finished halted=%0d with %0d mismatches.", sb.halted, sb.mismatches);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
